// ===== hw/rtl/bcp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcp_pkg
// Shared types, register codes and constants of the balance cascade PID step.
// ----------------------------------------------------------------------------
package bcp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 29;

  localparam logic [CFG_IDX_W-1:0] REG_BALANCE_ANGLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_KP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_KD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_KP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_KD      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_TARGET  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_LIMIT   = 3'd7;

  localparam logic signed [16:0] BALANCE_ANGLE_RST = -17'sd1280;
  localparam logic signed [28:0] UPRIGHT_KP_RST    = 29'sd18350080;
  localparam logic signed [28:0] UPRIGHT_KD_RST    = 29'sd43909;
  localparam logic signed [28:0] SPEED_KP_RST      = -29'sd47186;

  localparam logic signed [13:0] PWM_MAX        = 14'sd7200;
  localparam logic signed [15:0] INTEGRAL_LIMIT = 16'sd20000;

  // x/10 = (x * REC10) >> 23, exact for x < 2^22
  localparam logic [19:0] REC10    = 20'd838861;
  // x/25 = (x * REC25) >> 33, exact for x < 2^30
  localparam logic [28:0] REC25    = 29'd343597384;
  // 200 * 2^23: speed term beyond this saturates
  localparam logic [30:0] VMAG_CAP = 31'd1677721600;
  localparam logic [23:0] VEL_SAT  = 24'd8388607;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_FILT,
    OP_FE,
    OP_INT,
    OP_SOP,
    OP_VMAG,
    OP_VMUL,
    OP_VEL,
    OP_EANG,
    OP_UPR,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    GAIN_SPEED_KP,
    GAIN_UPRIGHT_KP,
    GAIN_UPRIGHT_KD,
    GAIN_STEER_KP,
    GAIN_STEER_KD
  } gain_sel_t;

  typedef enum logic [2:0] {
    MOP_LO,
    MOP_HI,
    MOP_PITCH_RATE,
    MOP_YAW_RATE,
    MOP_TURN
  } mop_sel_t;

  typedef enum logic [1:0] {
    ACC_SH_0,
    ACC_SH_8,
    ACC_SH_17
  } acc_sh_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FILT,
    ST_FE,
    ST_INT,
    ST_SOP,
    ST_SPD_LO,
    ST_SPD_HI,
    ST_SPD_DR,
    ST_VMAG,
    ST_VMUL,
    ST_VEL,
    ST_EANG,
    ST_UPR_LO,
    ST_UPR_HI,
    ST_UPR_KD,
    ST_UPR_DR,
    ST_UPR,
    ST_OUT
  } ctl_state_t;

  typedef struct packed {
    op_t       op;
    logic      mul_en;
    gain_sel_t gain;
    mop_sel_t  mop;
    acc_sh_t   sh;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hw/rtl/balance_cascade_pid_step_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balance_cascade_pid_step_unit
// Cascaded speed PI / upright PD / turn PD controller for a two-wheel robot.
// out_valid rises once the sequencer has stepped through all loops and the
// output register is free. A new transaction is taken only once the last one is
//   done, as the loops share the 29x18 gain multiplier (seven products).
// A result waiting in the output register does not block the next input.
// Reset (synchronous, rst_n low): registers take their defaults, filter and
//   integral state clear, the output channel empties.
// ----------------------------------------------------------------------------
module balance_cascade_pid_step_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              in_left_speed,
  input  logic signed [15:0]              in_right_speed,
  input  logic signed [16:0]              in_pitch_angle,
  input  logic signed [15:0]              in_pitch_rate,
  input  logic signed [15:0]              in_yaw_rate,
  input  logic signed [15:0]              in_turn_command,
  input  logic                            in_stop_request,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [13:0]              out_motor_left,
  output logic signed [13:0]              out_motor_right
);

  bcp_pkg::dp_cmd_t cmd;
  bcp_pkg::dp_sts_t sts;

  bcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bcp_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_left_speed   (in_left_speed),
    .in_right_speed  (in_right_speed),
    .in_pitch_angle  (in_pitch_angle),
    .in_pitch_rate   (in_pitch_rate),
    .in_yaw_rate     (in_yaw_rate),
    .in_turn_command (in_turn_command),
    .in_stop_request (in_stop_request),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_motor_left  (out_motor_left),
    .out_motor_right (out_motor_right)
  );

endmodule

// ===== hw/rtl/bcp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcp_ctrl
// Sequencer: steps the datapath through filter, speed, upright and turn loops.
// ----------------------------------------------------------------------------
module bcp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bcp_pkg::dp_sts_t  sts,
  output bcp_pkg::dp_cmd_t  cmd
);

  bcp_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.op     = bcp_pkg::OP_NONE;
    cmd.mul_en = 1'b0;
    cmd.gain   = bcp_pkg::GAIN_SPEED_KP;
    cmd.mop    = bcp_pkg::MOP_LO;
    cmd.sh     = bcp_pkg::ACC_SH_0;
    case (state_r)
      bcp_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = bcp_pkg::OP_CAPTURE;
          state_nxt = bcp_pkg::ST_FILT;
        end
      end
      bcp_pkg::ST_FILT: begin
        cmd.op     = bcp_pkg::OP_FILT;
        cmd.mul_en = 1'b1;
        cmd.gain   = bcp_pkg::GAIN_STEER_KP;
        cmd.mop    = bcp_pkg::MOP_TURN;
        state_nxt  = bcp_pkg::ST_FE;
      end
      bcp_pkg::ST_FE: begin
        cmd.op     = bcp_pkg::OP_FE;
        cmd.mul_en = 1'b1;
        cmd.gain   = bcp_pkg::GAIN_STEER_KD;
        cmd.mop    = bcp_pkg::MOP_YAW_RATE;
        state_nxt  = bcp_pkg::ST_INT;
      end
      bcp_pkg::ST_INT: begin
        cmd.op    = bcp_pkg::OP_INT;
        state_nxt = bcp_pkg::ST_SOP;
      end
      bcp_pkg::ST_SOP: begin
        cmd.op    = bcp_pkg::OP_SOP;
        state_nxt = bcp_pkg::ST_SPD_LO;
      end
      bcp_pkg::ST_SPD_LO: begin
        cmd.mul_en = 1'b1;
        cmd.gain   = bcp_pkg::GAIN_SPEED_KP;
        cmd.mop    = bcp_pkg::MOP_LO;
        state_nxt  = bcp_pkg::ST_SPD_HI;
      end
      bcp_pkg::ST_SPD_HI: begin
        cmd.mul_en = 1'b1;
        cmd.gain   = bcp_pkg::GAIN_SPEED_KP;
        cmd.mop    = bcp_pkg::MOP_HI;
        cmd.sh     = bcp_pkg::ACC_SH_17;
        state_nxt  = bcp_pkg::ST_SPD_DR;
      end
      bcp_pkg::ST_SPD_DR: begin
        state_nxt = bcp_pkg::ST_VMAG;
      end
      bcp_pkg::ST_VMAG: begin
        cmd.op    = bcp_pkg::OP_VMAG;
        state_nxt = bcp_pkg::ST_VMUL;
      end
      bcp_pkg::ST_VMUL: begin
        cmd.op    = bcp_pkg::OP_VMUL;
        state_nxt = bcp_pkg::ST_VEL;
      end
      bcp_pkg::ST_VEL: begin
        cmd.op    = bcp_pkg::OP_VEL;
        state_nxt = bcp_pkg::ST_EANG;
      end
      bcp_pkg::ST_EANG: begin
        cmd.op    = bcp_pkg::OP_EANG;
        state_nxt = bcp_pkg::ST_UPR_LO;
      end
      bcp_pkg::ST_UPR_LO: begin
        cmd.mul_en = 1'b1;
        cmd.gain   = bcp_pkg::GAIN_UPRIGHT_KP;
        cmd.mop    = bcp_pkg::MOP_LO;
        state_nxt  = bcp_pkg::ST_UPR_HI;
      end
      bcp_pkg::ST_UPR_HI: begin
        cmd.mul_en = 1'b1;
        cmd.gain   = bcp_pkg::GAIN_UPRIGHT_KP;
        cmd.mop    = bcp_pkg::MOP_HI;
        cmd.sh     = bcp_pkg::ACC_SH_17;
        state_nxt  = bcp_pkg::ST_UPR_KD;
      end
      bcp_pkg::ST_UPR_KD: begin
        cmd.mul_en = 1'b1;
        cmd.gain   = bcp_pkg::GAIN_UPRIGHT_KD;
        cmd.mop    = bcp_pkg::MOP_PITCH_RATE;
        cmd.sh     = bcp_pkg::ACC_SH_8;
        state_nxt  = bcp_pkg::ST_UPR_DR;
      end
      bcp_pkg::ST_UPR_DR: begin
        state_nxt = bcp_pkg::ST_UPR;
      end
      bcp_pkg::ST_UPR: begin
        cmd.op    = bcp_pkg::OP_UPR;
        state_nxt = bcp_pkg::ST_OUT;
      end
      bcp_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.op    = bcp_pkg::OP_OUT;
          state_nxt = bcp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bcp_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != bcp_pkg::ST_IDLE);

endmodule

// ===== hw/rtl/bcp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcp_datapath
// Config registers, loop state, shared gain multiplier with accumulator,
// reciprocal dividers and the output register.
// ----------------------------------------------------------------------------
module bcp_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [bcp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bcp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic signed [15:0]                   in_left_speed,
  input  logic signed [15:0]                   in_right_speed,
  input  logic signed [16:0]                   in_pitch_angle,
  input  logic signed [15:0]                   in_pitch_rate,
  input  logic signed [15:0]                   in_yaw_rate,
  input  logic signed [15:0]                   in_turn_command,
  input  logic                                 in_stop_request,
  input  bcp_pkg::dp_cmd_t                     cmd,
  output bcp_pkg::dp_sts_t                     sts,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic signed [13:0]                   out_motor_left,
  output logic signed [13:0]                   out_motor_right
);

  function automatic logic signed [13:0] sat_pwm(input logic signed [38:0] v);
    logic signed [38:0] lim;
    logic signed [13:0] res;
    lim = 39'(bcp_pkg::PWM_MAX);
    if (v > lim) begin
      res = bcp_pkg::PWM_MAX;
    end else if (v < -lim) begin
      res = -bcp_pkg::PWM_MAX;
    end else begin
      res = v[13:0];
    end
    return res;
  endfunction

  // config registers
  logic signed [16:0] balance_angle_r;
  logic signed [28:0] upright_kp_r;
  logic signed [28:0] upright_kd_r;
  logic signed [28:0] speed_kp_r;
  logic signed [28:0] steer_kp_r;
  logic signed [28:0] steer_kd_r;
  logic signed [13:0] speed_target_r;
  logic [14:0]        steer_limit_r;

  // captured transaction
  logic signed [15:0] left_r, right_r, prate_r, yaw_r, cmd_r;
  logic signed [16:0] pitch_r;
  logic               stop_r;

  // loop state
  logic signed [17:0] fe_r, fe_nxt;
  logic signed [15:0] si_r, si_nxt;

  // working registers
  logic [40:0]        prod10_r, prod10_nxt;
  logic               fneg_r;
  logic signed [33:0] opnd_r, opnd_nxt;
  logic signed [29:0] trn_r, trn_nxt;
  logic [30:0]        vmag_r, vmag_nxt;
  logic               vneg_r;
  logic [56:0]        prod25_r, prod25_nxt;
  logic signed [23:0] vel_r, vel_nxt;
  logic signed [37:0] upr_r, upr_nxt;

  // shared multiplier / accumulator
  logic signed [28:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [46:0] prod_r, prod_nxt;
  logic               pend_r;
  bcp_pkg::acc_sh_t   pend_sh_r;
  logic signed [63:0] acc_r, acc_nxt, acc_add;

  logic               out_valid_r;
  logic signed [13:0] motor_left_r, motor_right_r;

  // combinational temporaries
  logic signed [16:0] turn_ext, lim_ext;
  logic signed [15:0] cmd_clamp;
  logic signed [17:0] err_w;
  logic signed [21:0] num_w;
  logic [20:0]        num_mag;
  logic [17:0]        fe_q;
  logic signed [18:0] isum;
  logic signed [18:0] ilim;
  logic signed [63:0] tbias, ubias, acc_abs;
  logic [47:0]        vshift;
  logic [23:0]        vq, vm;
  logic signed [38:0] diff_l, diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      balance_angle_r <= bcp_pkg::BALANCE_ANGLE_RST;
      upright_kp_r    <= bcp_pkg::UPRIGHT_KP_RST;
      upright_kd_r    <= bcp_pkg::UPRIGHT_KD_RST;
      speed_kp_r      <= bcp_pkg::SPEED_KP_RST;
      steer_kp_r      <= '0;
      steer_kd_r      <= '0;
      speed_target_r  <= '0;
      steer_limit_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bcp_pkg::REG_BALANCE_ANGLE: balance_angle_r <= cfg_wdata[16:0];
        bcp_pkg::REG_UPRIGHT_KP:    upright_kp_r    <= cfg_wdata[28:0];
        bcp_pkg::REG_UPRIGHT_KD:    upright_kd_r    <= cfg_wdata[28:0];
        bcp_pkg::REG_SPEED_KP:      speed_kp_r      <= cfg_wdata[28:0];
        bcp_pkg::REG_STEER_KP:      steer_kp_r      <= cfg_wdata[28:0];
        bcp_pkg::REG_STEER_KD:      steer_kd_r      <= cfg_wdata[28:0];
        bcp_pkg::REG_SPEED_TARGET:  speed_target_r  <= cfg_wdata[13:0];
        bcp_pkg::REG_STEER_LIMIT:   steer_limit_r   <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // turn command clamp
  always_comb begin
    turn_ext = 17'(in_turn_command);
    lim_ext  = $signed({2'b00, steer_limit_r});
    if (turn_ext > lim_ext) begin
      cmd_clamp = lim_ext[15:0];
    end else if (turn_ext < -lim_ext) begin
      cmd_clamp = 16'(-lim_ext);
    end else begin
      cmd_clamp = in_turn_command;
    end
  end

  // speed filter: (3*err + 7*fe) / 10, truncated toward zero
  always_comb begin
    err_w      = 18'(left_r) + 18'(right_r) - 18'(speed_target_r);
    num_w      = (22'(err_w) <<< 1) + 22'(err_w) + (22'(fe_r) <<< 3) - 22'(fe_r);
    num_mag    = num_w[21] ? 21'(-num_w) : 21'(num_w);
    prod10_nxt = 41'(num_mag) * 41'(bcp_pkg::REC10);
    fe_q       = prod10_r[40:23];
    fe_nxt     = fneg_r ? -$signed(fe_q) : $signed(fe_q);
  end

  // integral with clamp and stop clear
  always_comb begin
    isum = 19'(si_r) + 19'(fe_r);
    ilim = 19'(bcp_pkg::INTEGRAL_LIMIT);
    if (stop_r) begin
      si_nxt = '0;
    end else if (isum > ilim) begin
      si_nxt = bcp_pkg::INTEGRAL_LIMIT;
    end else if (isum < -ilim) begin
      si_nxt = -bcp_pkg::INTEGRAL_LIMIT;
    end else begin
      si_nxt = isum[15:0];
    end
  end

  // operand loads and loop results
  always_comb begin
    opnd_nxt = opnd_r;
    if (cmd.op == bcp_pkg::OP_SOP) begin
      opnd_nxt = (34'(fe_r) <<< 7) + (34'(fe_r) <<< 6) + (34'(fe_r) <<< 3) + 34'(si_r);
    end else if (cmd.op == bcp_pkg::OP_EANG) begin
      opnd_nxt = 34'(pitch_r) - 34'(balance_angle_r) - (34'(vel_r) <<< 8);
    end

    tbias   = acc_r + (acc_r[63] ? 64'sd65535 : 64'sd0);
    trn_nxt = tbias[45:16];

    acc_abs  = acc_r[63] ? -acc_r : acc_r;
    vshift   = acc_abs[63:16];
    vmag_nxt = (vshift >= 48'(bcp_pkg::VMAG_CAP)) ? bcp_pkg::VMAG_CAP : vshift[30:0];

    prod25_nxt = 57'(vmag_r[30:3]) * 57'(bcp_pkg::REC25);
    vq         = prod25_r[56:33];
    vm         = (vq > bcp_pkg::VEL_SAT) ? bcp_pkg::VEL_SAT : vq;
    vel_nxt    = vneg_r ? -$signed(vm) : $signed(vm);

    ubias   = acc_r + (acc_r[63] ? 64'sd16777215 : 64'sd0);
    upr_nxt = ubias[61:24];

    diff_l = 39'(upr_r) - 39'(trn_r);
    diff_r = 39'(upr_r) + 39'(trn_r);
  end

  // shared gain multiplier
  always_comb begin
    case (cmd.gain)
      bcp_pkg::GAIN_SPEED_KP:   mul_a = speed_kp_r;
      bcp_pkg::GAIN_UPRIGHT_KP: mul_a = upright_kp_r;
      bcp_pkg::GAIN_UPRIGHT_KD: mul_a = upright_kd_r;
      bcp_pkg::GAIN_STEER_KP:   mul_a = steer_kp_r;
      bcp_pkg::GAIN_STEER_KD:   mul_a = steer_kd_r;
      default:                  mul_a = '0;
    endcase
    case (cmd.mop)
      bcp_pkg::MOP_LO:         mul_b = $signed({1'b0, opnd_r[16:0]});
      bcp_pkg::MOP_HI:         mul_b = 18'($signed(opnd_r[33:17]));
      bcp_pkg::MOP_PITCH_RATE: mul_b = 18'(prate_r);
      bcp_pkg::MOP_YAW_RATE:   mul_b = 18'(yaw_r);
      bcp_pkg::MOP_TURN:       mul_b = 18'(cmd_r);
      default:                 mul_b = '0;
    endcase
    prod_nxt = 47'(mul_a) * 47'(mul_b);

    case (pend_sh_r)
      bcp_pkg::ACC_SH_0:  acc_add = 64'(prod_r);
      bcp_pkg::ACC_SH_8:  acc_add = 64'(prod_r) <<< 8;
      bcp_pkg::ACC_SH_17: acc_add = 64'(prod_r) <<< 17;
      default:            acc_add = '0;
    endcase
    if (cmd.op == bcp_pkg::OP_CAPTURE || cmd.op == bcp_pkg::OP_SOP ||
        cmd.op == bcp_pkg::OP_EANG) begin
      acc_nxt = '0;
    end else begin
      acc_nxt = acc_r + (pend_r ? acc_add : 64'sd0);
    end
  end

  // control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_r        <= '0;
      si_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == bcp_pkg::OP_FE) begin
        fe_r <= fe_nxt;
      end
      if (cmd.op == bcp_pkg::OP_INT) begin
        si_r <= si_nxt;
      end
      pend_r <= cmd.mul_en;
      if (cmd.op == bcp_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == bcp_pkg::OP_CAPTURE) begin
      left_r  <= in_left_speed;
      right_r <= in_right_speed;
      pitch_r <= in_pitch_angle;
      prate_r <= in_pitch_rate;
      yaw_r   <= in_yaw_rate;
      cmd_r   <= cmd_clamp;
      stop_r  <= in_stop_request;
    end
    if (cmd.op == bcp_pkg::OP_FILT) begin
      prod10_r <= prod10_nxt;
      fneg_r   <= num_w[21];
    end
    if (cmd.op == bcp_pkg::OP_SOP) begin
      trn_r <= trn_nxt;
    end
    if (cmd.op == bcp_pkg::OP_VMAG) begin
      vmag_r <= vmag_nxt;
      vneg_r <= acc_r[63];
    end
    if (cmd.op == bcp_pkg::OP_VMUL) begin
      prod25_r <= prod25_nxt;
    end
    if (cmd.op == bcp_pkg::OP_VEL) begin
      vel_r <= vel_nxt;
    end
    if (cmd.op == bcp_pkg::OP_UPR) begin
      upr_r <= upr_nxt;
    end
    if (cmd.op == bcp_pkg::OP_OUT) begin
      motor_left_r  <= sat_pwm(diff_l);
      motor_right_r <= sat_pwm(diff_r);
    end
    opnd_r    <= opnd_nxt;
    prod_r    <= prod_nxt;
    pend_sh_r <= cmd.sh;
    acc_r     <= acc_nxt;
  end

  assign sts.out_free    = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_motor_left  = motor_left_r;
  assign out_motor_right = motor_right_r;

endmodule
